/* hw/rtl/paq_pkg.sv */
// Package for the aging priority queue: command and status codes, field widths,
// and the control bundle that the top level broadcasts to every cell.
// Used by paq_cell, priority_queue_with_aging_core and paq_checker.
`timescale 1ns / 1ps
`default_nettype none

package paq_pkg;

  localparam int TagW    = 16;
  localparam int PriW    = 16;
  localparam int CmdW    = 2;
  localparam int StatusW = 2;
  localparam int OccW    = 5;
  localparam int DefaultDepth = 16;

  localparam logic signed [PriW-1:0] PriMin = {1'b1, {(PriW-1){1'b0}}};

  typedef enum logic [CmdW-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_AGE   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One command, broadcast to the whole row of cells.
  typedef struct packed {
    logic                   enq;
    logic                   deq;
    logic                   age;
    logic [TagW-1:0]        tag;
    logic signed [PriW-1:0] pri;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/paq_cell.sv */
// One slot of the sorted row: holds a tag and a priority, and trades them with
// its neighbors on insert and remove. Depends on paq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module paq_cell (
  input  wire logic                           clk,
  input  wire paq_pkg::cell_ctl_t             ctl,
  input  wire logic                           occ,        // slot holds an entry
  input  wire logic                           left_gt,    // left neighbor outranks new entry
  input  wire logic [paq_pkg::TagW-1:0]       left_tag,
  input  wire logic signed [paq_pkg::PriW-1:0] left_pri,
  input  wire logic [paq_pkg::TagW-1:0]       right_tag,
  input  wire logic signed [paq_pkg::PriW-1:0] right_pri,
  output logic                                gt,         // occupied and priority above new
  output logic [paq_pkg::TagW-1:0]            tag,
  output logic signed [paq_pkg::PriW-1:0]     pri
);
  import paq_pkg::*;

  assign gt = occ && (pri > ctl.pri);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      // shift right behind the insertion point, take the new entry at it
      if (left_gt) begin
        tag <= left_tag;
        pri <= left_pri;
      end else if (gt || !occ) begin
        tag <= ctl.tag;
        pri <= ctl.pri;
      end
    end else if (ctl.deq) begin
      tag <= right_tag;
      pri <= right_pri;
    end else if (ctl.age && occ && (pri != PriMin)) begin
      pri <= pri - PriW'(1);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/priority_queue_with_aging_core.sv */
// Aging priority queue: a row of DEPTH cells kept sorted by priority.
// Each accepted request's result is registered in the result register and shown on m_*.
// Throughput: one request per cycle while s_tready is high; each cell compares and shifts in parallel.
// s_tready stays high while the result register is empty or being drained.
// Reset clears the entry count and the result valid; cell contents are not
// cleared, since only slots below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module priority_queue_with_aging_core #(
  parameter int DEPTH = paq_pkg::DefaultDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] data_in, [31:16] priority_in
  input  wire logic [1:0]  s_tuser,   // [1:0] cmd
  // result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [15:0] data_out, [17:16] status, [22:18] occupancy
);
  import paq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  // entry count: slots [0, count) are live, slot 0 is the head
  logic [CntW-1:0] count, count_next;

  logic accept;
  cmd_t cmd;
  logic full, empty;
  cell_ctl_t ctl;

  logic [TagW-1:0]        cell_tag [DEPTH];
  logic signed [PriW-1:0] cell_pri [DEPTH];
  logic                   cell_gt  [DEPTH];

  // result register
  logic [TagW-1:0] res_data, res_data_next;
  status_t         res_status, res_status_next;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign cmd      = cmd_t'(s_tuser);
  assign full     = (count == CntW'(DEPTH));
  assign empty    = (count == '0);

  // broadcast the command; a dropped enqueue or an empty dequeue leaves cells alone
  always_comb begin
    ctl.enq = accept && (cmd == CMD_ENQ) && !full;
    ctl.deq = accept && (cmd == CMD_DEQ) && !empty;
    ctl.age = accept && (cmd == CMD_AGE);
    ctl.tag = s_tdata[15:0];
    ctl.pri = s_tdata[31:16];
  end

  // the row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   l_gt;
    logic [TagW-1:0]        l_tag;
    logic signed [PriW-1:0] l_pri;
    logic [TagW-1:0]        r_tag;
    logic signed [PriW-1:0] r_pri;

    if (i == 0) begin : g_head
      assign l_gt  = 1'b0;
      assign l_tag = '0;
      assign l_pri = '0;
    end else begin : g_body
      assign l_gt  = cell_gt[i-1];
      assign l_tag = cell_tag[i-1];
      assign l_pri = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // hold on remove; the slot becomes dead anyway
      assign r_tag = cell_tag[i];
      assign r_pri = cell_pri[i];
    end else begin : g_inner
      assign r_tag = cell_tag[i+1];
      assign r_pri = cell_pri[i+1];
    end

    paq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CntW'(i) < count),
      .left_gt   (l_gt),
      .left_tag  (l_tag),
      .left_pri  (l_pri),
      .right_tag (r_tag),
      .right_pri (r_pri),
      .gt        (cell_gt[i]),
      .tag       (cell_tag[i]),
      .pri       (cell_pri[i])
    );
  end

  // next count and the result of this request
  always_comb begin
    count_next      = count;
    res_data_next   = '0;
    res_status_next = ST_OK;
    unique case (cmd)
      CMD_ENQ: begin
        if (full) res_status_next = ST_FULL;
        else      count_next      = count + CntW'(1);
      end
      CMD_DEQ: begin
        if (empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          res_data_next = cell_tag[0];
          count_next    = count - CntW'(1);
        end
      end
      CMD_AGE:   count_next = count;
      CMD_CLEAR: count_next = '0;
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        // drop the result once taken
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload of the result register; occupancy is sampled from the updated count
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data   <= res_data_next;
      res_status <= res_status_next;
    end
  end

  assign m_tdata = {1'b0, OccW'(count), res_status, res_data};

endmodule

`default_nettype wire

/* hw/rtl/paq_checker.sv */
// Port-level checks for the aging priority queue, bound to the top level.
// Depends on paq_pkg and priority_queue_with_aging_core.
`timescale 1ns / 1ps
`default_nettype none

module paq_checker #(
  parameter int DEPTH = paq_pkg::DefaultDepth
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);
  import paq_pkg::*;

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // the block never stalls requests while its result register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request stalled with empty result register");

  // a failed request returns no tag
  a_fail_no_tag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] != ST_OK) |-> (m_tdata[15:0] == '0))
    else $error("tag returned with error status");

  // a dropped enqueue only happens on a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] == ST_FULL) |-> (m_tdata[22:18] == OccW'(DEPTH)))
    else $error("enqueue dropped below full");

endmodule

bind priority_queue_with_aging_core paq_checker #(.DEPTH(DEPTH)) u_paq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
